@@ hw/rtl/rrcf_pkg.sv @@
// Package for the radial run cluster finder: widths, register map, reset values and run record.
`default_nettype none
package rrcf_pkg;

  localparam int unsigned RadiusW  = 16;
  localparam int unsigned CountW   = 16;
  localparam int unsigned MarginW  = 13;
  localparam int unsigned BoundW   = 17;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned AddrW    = 4;
  localparam int unsigned ApbDataW = 32;

  localparam logic [CountW-1:0]  MinCountRst  = 16'd25;
  localparam logic [RadiusW-1:0] JumpThrRst   = 16'd77;
  localparam logic [MarginW-1:0] MarginRst    = 13'd128;
  localparam logic [CountW-1:0]  CountMax     = {CountW{1'b1}};

  typedef enum logic [1:0] {
    RegMinCount = 2'd0,
    RegJumpThr  = 2'd1,
    RegMargin   = 2'd2,
    RegNone     = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [RadiusW-1:0] first;
    logic [RadiusW-1:0] latest;
    logic [CountW-1:0]  length;
    logic               reported;
  } run_t;

endpackage
`default_nettype wire

@@ hw/rtl/radial_run_cluster_finder.sv @@
// Radial run cluster finder: run tracking per bin with one result per bin.
// A result appears on the master side in the cycle after the transfer of the item that
// causes it. Throughput: one item per cycle unless stalled; the run compare and update is
// one subtract, one compare and a saturating count ahead of the run and result registers.
// The slave side stalls only while an unread result waits and the master side is stalled.
// Reset: run state and output valid clear; registers return to 25, 77 and 128.
`default_nettype none
module radial_run_cluster_finder (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // APB-style configuration port
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [rrcf_pkg::AddrW-1:0]           paddr,
  input  wire logic [rrcf_pkg::ApbDataW-1:0]        pwdata,
  output logic      [rrcf_pkg::ApbDataW-1:0]        prdata,
  output logic                                      pready,
  // input stream
  input  wire logic                                 s_axis_tvalid_i,
  output logic                                      s_axis_tready_o,
  // tdata: radius [15:0]
  input  wire logic [rrcf_pkg::RadiusW-1:0]         s_axis_tdata_i,
  // tlast: bin_end
  input  wire logic                                 s_axis_tlast_i,
  // result stream
  output logic                                      m_axis_tvalid_o,
  input  wire logic                                 m_axis_tready_i,
  // tdata: inner_bound [16:0], outer_bound [33:17], zero [39:34]
  output logic      [rrcf_pkg::OutDataW-1:0]        m_axis_tdata_o,
  // tuser: found
  output logic                                      m_axis_tuser_o
);

  localparam int unsigned BW = rrcf_pkg::BoundW;

  logic [rrcf_pkg::CountW-1:0]  min_count_q;
  logic [rrcf_pkg::RadiusW-1:0] jump_thr_q;
  logic [rrcf_pkg::MarginW-1:0] margin_q;

  rrcf_pkg::run_t run_q, run_d;

  logic          m_valid_q;
  logic [BW-1:0] inner_q, outer_q, inner_d, outer_d;
  logic          found_q, found_d;

  logic                         in_acc, emit;
  logic                         cfg_wr;
  rrcf_pkg::reg_idx_e           cfg_idx;
  logic [rrcf_pkg::RadiusW-1:0] step;
  logic                         cont, close;
  rrcf_pkg::run_t               run_n;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = rrcf_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_count_q <= rrcf_pkg::MinCountRst;
      jump_thr_q  <= rrcf_pkg::JumpThrRst;
      margin_q    <= rrcf_pkg::MarginRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        rrcf_pkg::RegMinCount: min_count_q <= pwdata[rrcf_pkg::CountW-1:0];
        rrcf_pkg::RegJumpThr:  jump_thr_q  <= pwdata[rrcf_pkg::RadiusW-1:0];
        rrcf_pkg::RegMargin:   margin_q    <= pwdata[rrcf_pkg::MarginW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      rrcf_pkg::RegMinCount: prdata = {16'd0, min_count_q};
      rrcf_pkg::RegJumpThr:  prdata = {16'd0, jump_thr_q};
      rrcf_pkg::RegMargin:   prdata = {19'd0, margin_q};
      default:               prdata = '0;
    endcase
  end

  // accept whenever the result register is free or drains this cycle
  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    step = (run_q.latest >= s_axis_tdata_i) ? run_q.latest - s_axis_tdata_i
                                            : s_axis_tdata_i - run_q.latest;
    cont  = (run_q.length != '0) && (step <= jump_thr_q);
    close = !cont && (run_q.length >= min_count_q);

    run_n = run_q;
    if (!run_q.reported) begin
      if (cont) begin
        run_n.latest = s_axis_tdata_i;
        if (run_q.length != rrcf_pkg::CountMax) run_n.length = run_q.length + 1'b1;
      end else if (close) begin
        run_n.reported = 1'b1;
      end else begin
        run_n.first  = s_axis_tdata_i;
        run_n.latest = s_axis_tdata_i;
        run_n.length = 16'd1;
      end
    end

    emit = !run_q.reported && (close || s_axis_tlast_i);

    // a closing report leaves first and latest untouched, so both paths read run_n
    found_d = close || ((run_n.length >= min_count_q) && (run_n.first != '0));
    if (found_d) begin
      inner_d = {1'b0, run_n.first} - {{(BW-rrcf_pkg::MarginW){1'b0}}, margin_q};
      outer_d = {1'b0, run_n.latest} + {{(BW-rrcf_pkg::MarginW){1'b0}}, margin_q};
    end else begin
      inner_d = '0;
      outer_d = '0;
    end

    // the last item of a bin always clears the run
    run_d = s_axis_tlast_i ? '0 : run_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else if (in_acc) begin
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (in_acc && emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      inner_q <= inner_d;
      outer_q <= outer_d;
      found_q <= found_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(rrcf_pkg::OutDataW-2*BW){1'b0}}, outer_q, inner_q};
  assign m_axis_tuser_o  = found_q;

  // a result without a cluster carries zero bounds
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !found_q) |-> (inner_q == '0 && outer_q == '0))
    else $error("result without cluster has nonzero bounds");

  // the last item of a bin leaves an empty, unreported run
  a_bin_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast_i) |=> (run_q.length == '0 && !run_q.reported))
    else $error("run state not cleared at end of bin");

  // a reported bin produces no further result, not even at its last item
  a_no_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && run_q.reported && m_axis_tready_i) |=> !m_valid_q)
    else $error("second result in a reported bin");

endmodule
`default_nettype wire
